FILE: rtl/core/fau_pkg.sv
// fau_pkg: shared widths, types, operation codes and helpers of the fraction unit
// no dependencies; imported by every module in rtl/core

package fau_pkg;

  // operand and result widths
  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH + 1;
  localparam int SUM_W         = PROD_W + 1;
  localparam int NUM_W         = 33;
  localparam int DEN_W         = 32;
  localparam int CMP_W         = 2;
  localparam int FUNC_W        = 3;
  localparam int STEP_W        = $clog2(OPERAND_WIDTH);

  typedef logic signed [OPERAND_WIDTH-1:0] opnd_t;
  typedef logic        [OPERAND_WIDTH-1:0] mag_t;
  typedef logic signed [PROD_W-1:0]        prod_t;
  typedef logic signed [SUM_W-1:0]         sum_t;
  typedef logic signed [NUM_W-1:0]         num_t;
  typedef logic signed [DEN_W-1:0]         den_t;
  typedef logic signed [CMP_W-1:0]         cmp_t;
  typedef logic        [STEP_W-1:0]        step_t;

  // last bit step of the serial units
  localparam step_t LAST_STEP = step_t'(OPERAND_WIDTH - 1);

  // compare outcomes
  localparam cmp_t CMP_LT = -2'sd1;
  localparam cmp_t CMP_EQ = 2'sd0;
  localparam cmp_t CMP_GT = 2'sd1;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_RED = 3'd4,
    FUNC_CMP = 3'd5
  } func_e;

  // magnitude of a two's complement operand, the most negative value included
  function automatic mag_t magnitude(opnd_t v);
    mag_t m;
    if (v[OPERAND_WIDTH-1]) begin
      m = mag_t'(-v);
    end else begin
      m = mag_t'(v);
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/fau_mul.sv
// fau_mul: bit-serial signed multiplier, one multiplier bit per cycle
// depends on fau_pkg

module fau_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  fau_pkg::opnd_t mcand_i,
  input  fau_pkg::opnd_t mplier_i,
  output logic          done_o,
  output fau_pkg::prod_t prod_o
);
  import fau_pkg::*;

  logic signed [OPERAND_WIDTH:0]   hi_q, hi_d;
  logic        [OPERAND_WIDTH-1:0] lo_q, lo_d;
  opnd_t                           mc_q;
  step_t                           cnt_q;
  logic                            busy_q, done_q;
  logic                            last;
  logic signed [OPERAND_WIDTH+1:0] m_ext, addend, sum;

  // shift-add step; the sign bit of the multiplier weighs negative
  always_comb begin
    last  = (cnt_q == LAST_STEP);
    m_ext = {{2{mc_q[OPERAND_WIDTH-1]}}, mc_q};
    if (!lo_q[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -m_ext;
    end else begin
      addend = m_ext;
    end
    sum  = {hi_q[OPERAND_WIDTH], hi_q} + addend;
    hi_d = sum[OPERAND_WIDTH+1:1];
    lo_d = {sum[0], lo_q[OPERAND_WIDTH-1:1]};
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // partial product shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= mplier_i;
      mc_q <= mcand_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o = {hi_q, lo_q};
  assign done_o = done_q;

endmodule

FILE: rtl/core/fau_gcd.sv
// fau_gcd: binary gcd of two magnitudes, less shared twos, one step per cycle
// depends on fau_pkg; also returns both inputs with shared factors of two removed

module fau_gcd (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  fau_pkg::mag_t a_i,
  input  fau_pkg::mag_t b_i,
  output logic          done_o,
  output fau_pkg::mag_t g_o,
  output fau_pkg::mag_t a_red_o,
  output fau_pkg::mag_t b_red_o
);
  import fau_pkg::*;

  mag_t u_q, v_q, x_q, y_q, g_q;
  mag_t u_d, v_d, x_d, y_d;
  logic busy_q, done_q;
  logic finish;

  // one binary gcd step
  always_comb begin
    u_d    = u_q;
    v_d    = v_q;
    x_d    = x_q;
    y_d    = y_q;
    finish = (u_q == '0) || (v_q == '0);
    if (!finish) begin
      if (!u_q[0] && !v_q[0]) begin
        // common factor of two leaves the dividends too
        u_d = u_q >> 1;
        v_d = v_q >> 1;
        x_d = x_q >> 1;
        y_d = y_q >> 1;
      end else if (!u_q[0]) begin
        u_d = u_q >> 1;
      end else if (!v_q[0]) begin
        v_d = v_q >> 1;
      end else if (u_q >= v_q) begin
        u_d = (u_q - v_q) >> 1;
      end else begin
        v_d = (v_q - u_q) >> 1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && finish;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && finish) begin
        busy_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= a_i;
      v_q <= b_i;
      x_q <= a_i;
      y_q <= b_i;
    end else if (busy_q) begin
      u_q <= u_d;
      v_q <= v_d;
      x_q <= x_d;
      y_q <= y_d;
      if (finish) begin
        g_q <= (u_q == '0) ? v_q : u_q;
      end
    end
  end

  assign done_o  = done_q;
  assign g_o     = g_q;
  assign a_red_o = x_q;
  assign b_red_o = y_q;

endmodule

FILE: rtl/core/fau_div.sv
// fau_div: restoring bit-serial unsigned divider, one quotient bit per cycle
// depends on fau_pkg

module fau_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  fau_pkg::mag_t dividend_i,
  input  fau_pkg::mag_t divisor_i,
  output logic          done_o,
  output fau_pkg::mag_t quot_o
);
  import fau_pkg::*;

  mag_t                     rem_q, quo_q, dsr_q;
  mag_t                     rem_d, quo_d;
  step_t                    cnt_q;
  logic                     busy_q, done_q;
  logic                     last;
  logic [OPERAND_WIDTH:0]   trial, diff;
  logic                     qbit;

  // shift in one dividend bit and try the subtraction
  always_comb begin
    last  = (cnt_q == LAST_STEP);
    trial = {rem_q, quo_q[OPERAND_WIDTH-1]};
    diff  = trial - {1'b0, dsr_q};
    qbit  = (trial >= {1'b0, dsr_q});
    rem_d = qbit ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
    quo_d = {quo_q[OPERAND_WIDTH-2:0], qbit};
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: rtl/core/fraction_arithmetic_unit.sv
// Fraction arithmetic unit: add, subtract, multiply, divide, reduce and compare
// of two signed fractions. Usage:
//   in channel  : in_valid_i / in_ready_o carry func_i and the four operands;
//                 a request is taken when both are high. in_ready_o is high
//                 only while no request is in work (one request at a time).
//   out channel : out_valid_o / out_ready_i carry res_num_o, res_den_o,
//                 cmp_result_o and status_o from an output register, so a new
//                 request is taken while the previous result still waits.
//   sequence    : add, subtract, multiply, divide and compare run on three
//                 bit-serial multipliers of one operand bit per cycle (16
//                 steps). Reduce runs the gcd, then 16 steps of two
//                 bit-serial dividers; zero over zero skips the dividers.
//                 Unused codes go straight to an error result.
//   throughput  : a new request is taken only after the last result has
//                 moved into the output register.
//   reset       : rst_ni low clears all control; no result is pending after.
//   stall       : a held result blocks the next one from leaving the last
//                 stage; nothing is dropped.
// depends on fau_pkg, fau_mul, fau_gcd, fau_div

module fraction_arithmetic_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fau_pkg::FUNC_W-1:0]      func_i,
  input  fau_pkg::opnd_t                  a_num_i,
  input  fau_pkg::opnd_t                  a_den_i,
  input  fau_pkg::opnd_t                  b_num_i,
  input  fau_pkg::opnd_t                  b_den_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fau_pkg::num_t                   res_num_o,
  output fau_pkg::den_t                   res_den_o,
  output fau_pkg::cmp_t                   cmp_result_o,
  output logic                            status_o
);
  import fau_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_GCD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e st_q, st_d;
  func_e  func_in;
  logic [FUNC_W-1:0] op_q;
  opnd_t  a_num_q, a_den_q;
  logic   accept, mul_start, gcd_start, div_start, out_load;

  prod_t  p0, p1, p2;
  logic   mul_done0, mul_done1, mul_done2;
  mag_t   gcd_g, gcd_a, gcd_b;
  logic   gcd_done, gcd_zero;
  mag_t   quo_num, quo_den;
  logic   div_done_num, div_done_den;

  num_t   res_num_q, num_v, nq;
  den_t   res_den_q, den_v, dq;
  cmp_t   cmp_q, cmp_v;
  logic   status_q, status_v, out_valid_q;
  sum_t   s0, s1, diff;

  assign func_in    = func_e'(func_i);
  assign in_ready_o = (st_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign gcd_zero   = (gcd_g == '0);
  assign div_start  = (st_q == ST_GCD) && gcd_done && !gcd_zero;
  assign out_load   = (st_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // request decode
  always_comb begin
    mul_start = 1'b0;
    gcd_start = 1'b0;
    unique case (func_in) inside
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV, FUNC_CMP: mul_start = accept;
      FUNC_RED:                                          gcd_start = accept;
      default: ;
    endcase
  end

  // cross products
  fau_mul u_mul0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (a_num_i),
    .mplier_i ((func_in == FUNC_MUL) ? b_num_i : b_den_i),
    .done_o   (mul_done0),
    .prod_o   (p0)
  );

  fau_mul u_mul1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (b_num_i),
    .mplier_i (a_den_i),
    .done_o   (mul_done1),
    .prod_o   (p1)
  );

  fau_mul u_mul2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (a_den_i),
    .mplier_i ((func_in == FUNC_DIV) ? b_num_i : b_den_i),
    .done_o   (mul_done2),
    .prod_o   (p2)
  );

  // gcd and exact division for reduce
  fau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (magnitude(a_num_i)),
    .b_i     (magnitude(a_den_i)),
    .done_o  (gcd_done),
    .g_o     (gcd_g),
    .a_red_o (gcd_a),
    .b_red_o (gcd_b)
  );

  fau_div u_div_num (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (gcd_a),
    .divisor_i  (gcd_g),
    .done_o     (div_done_num),
    .quot_o     (quo_num)
  );

  fau_div u_div_den (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (gcd_b),
    .divisor_i  (gcd_g),
    .done_o     (div_done_den),
    .quot_o     (quo_den)
  );

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (mul_start) begin
            st_d = ST_MUL;
          end else if (gcd_start) begin
            st_d = ST_GCD;
          end else begin
            st_d = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        if (mul_done0) begin
          st_d = ST_FIN;
        end
      end
      ST_GCD: begin
        if (gcd_done) begin
          st_d = gcd_zero ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done_num) begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // result assembly
  always_comb begin
    s0       = sum_t'(p0);
    s1       = sum_t'(p1);
    diff     = s0 - s1;
    nq       = num_t'(quo_num);
    dq       = den_t'(quo_den);
    num_v    = '0;
    den_v    = '0;
    cmp_v    = CMP_EQ;
    status_v = 1'b0;
    case (func_e'(op_q)) inside
      FUNC_ADD: begin
        num_v    = num_t'(s0 + s1);
        den_v    = den_t'(p2);
        status_v = (den_v == '0);
      end
      FUNC_SUB: begin
        num_v    = num_t'(diff);
        den_v    = den_t'(p2);
        status_v = (den_v == '0);
      end
      FUNC_MUL, FUNC_DIV: begin
        num_v    = num_t'(p0);
        den_v    = den_t'(p2);
        status_v = (den_v == '0);
      end
      FUNC_RED: begin
        if (gcd_zero) begin
          status_v = 1'b1;
        end else begin
          num_v    = a_num_q[OPERAND_WIDTH-1] ? -nq : nq;
          den_v    = a_den_q[OPERAND_WIDTH-1] ? -dq : dq;
          status_v = (den_v == '0);
        end
      end
      FUNC_CMP: begin
        // a negative denominator product flips the ordering
        if (diff != '0) begin
          cmp_v = (diff[SUM_W-1] == p2[PROD_W-1]) ? CMP_GT : CMP_LT;
        end
        status_v = (p2 == '0);
      end
      default: status_v = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= func_i;
      a_num_q <= a_num_i;
      a_den_q <= a_den_i;
    end
    if (out_load) begin
      res_num_q <= num_v;
      res_den_q <= den_v;
      cmp_q     <= cmp_v;
      status_q  <= status_v;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign res_num_o    = res_num_q;
  assign res_den_o    = res_den_q;
  assign cmp_result_o = cmp_q;
  assign status_o     = status_q;

`ifndef SYNTHESIS
  // multiplier lanes finish only while the sequencer waits on them, all together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done0 |-> (st_q == ST_MUL) && mul_done1 && mul_done2)
    else $error("multiplier lanes out of step with sequencer");

  // gcd finishes only during reduce
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_done |-> (st_q == ST_GCD))
    else $error("gcd done outside reduce");

  // both divider lanes finish together in the divide state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_num |-> (st_q == ST_DIV) && div_done_den)
    else $error("divider lanes out of step with sequencer");

  // a finished result waits while the output register is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN) && out_valid_q && !out_ready_i |=> (st_q == ST_FIN))
    else $error("result left the last stage while output was stalled");
`endif

endmodule

FILE: tb/fraction_arithmetic_unit_tb.sv
// testbench of fraction_arithmetic_unit: directed and random requests, results
// checked against a predictor of the fraction math; needs fau_pkg and the rtl
`timescale 1ns / 100ps

module fraction_arithmetic_unit_tb;
  import fau_pkg::*;

  // spare operation codes, answered with an error result
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  localparam int IDLE_PERCENT   = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 60;

  typedef struct packed {
    num_t num;
    den_t den;
    cmp_t cmp;
    logic status;
  } fraction_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i      = '0;
  opnd_t               a_num_i     = '0;
  opnd_t               a_den_i     = '0;
  opnd_t               b_num_i     = '0;
  opnd_t               b_den_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  num_t                res_num_o;
  den_t                res_den_o;
  cmp_t                cmp_result_o;
  logic                status_o;

  fraction_result_t    pending_results[$];
  int                  err_count   = 0;
  int                  idle_cycles = 0;
  bit                  no_idling   = 1'b0;

  fraction_arithmetic_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .a_num_i      (a_num_i),
    .a_den_i      (a_den_i),
    .b_num_i      (b_num_i),
    .b_den_i      (b_den_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_num_o    (res_num_o),
    .res_den_o    (res_den_o),
    .cmp_result_o (cmp_result_o),
    .status_o     (status_o)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // expected fraction result of one request
  function automatic fraction_result_t fraction_result(logic [FUNC_W-1:0] op, opnd_t an,
                                                       opnd_t ad, opnd_t bn, opnd_t bd);
    fraction_result_t r;
    longint           num;
    longint           den;
    longint           lhs;
    longint           rhs;
    longint           x;
    longint           y;
    longint           rem;
    num = 0;
    den = 0;
    r   = '0;
    case (op)
      FUNC_ADD: begin
        num = longint'(an) * bd + longint'(bn) * ad;
        den = longint'(ad) * bd;
        r.status = (den == 0);
      end
      FUNC_SUB: begin
        num = longint'(an) * bd - longint'(bn) * ad;
        den = longint'(ad) * bd;
        r.status = (den == 0);
      end
      FUNC_MUL: begin
        num = longint'(an) * bn;
        den = longint'(ad) * bd;
        r.status = (den == 0);
      end
      FUNC_DIV: begin
        num = longint'(an) * bd;
        den = longint'(ad) * bn;
        r.status = (den == 0);
      end
      FUNC_RED: begin
        // euclid on magnitudes, the most negative operand included
        x = (an < 0) ? -longint'(an) : longint'(an);
        y = (ad < 0) ? -longint'(ad) : longint'(ad);
        while (y != 0) begin
          rem = x % y;
          x   = y;
          y   = rem;
        end
        if (x == 0) begin
          r.status = 1'b1;
        end else begin
          num = longint'(an) / x;
          den = longint'(ad) / x;
          r.status = (den == 0);
        end
      end
      FUNC_CMP: begin
        lhs = longint'(an) * bd;
        rhs = longint'(bn) * ad;
        den = longint'(ad) * bd;
        // flip both sides when the denominator product is negative
        if (den < 0) begin
          lhs = -lhs;
          rhs = -rhs;
        end
        r.cmp    = (lhs > rhs) ? CMP_GT : ((lhs < rhs) ? CMP_LT : CMP_EQ);
        r.status = (den == 0);
        den = 0;
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    r.num = num_t'(num);
    r.den = den_t'(den);
    return r;
  endfunction

  // drive one request and hold it until taken
  task automatic send_request(logic [FUNC_W-1:0] op, opnd_t an, opnd_t ad, opnd_t bn,
                              opnd_t bd);
    if (!no_idling) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    a_num_i    <= an;
    a_den_i    <= ad;
    b_num_i    <= bn;
    b_den_i    <= bd;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(fraction_result(op, an, ad, bn, bd));
  endtask

  // stop sending until every result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // operand mix: extremes, small values and full range
  function automatic opnd_t random_operand();
    opnd_t v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = 16'sh7fff;
      2:       v = 16'sh8000;
      3:       v = ($urandom_range(1) != 0) ? 16'sh0001 : 16'shffff;
      4, 5:    v = opnd_t'(int'($urandom_range(40)) - 20);
      default: v = opnd_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic opnd_t random_denominator();
    opnd_t v;
    if ($urandom_range(19) == 0) begin
      v = '0;
    end else begin
      v = random_operand();
    end
    return v;
  endfunction

  // one random request, mostly well-formed with random content
  task automatic random_request();
    logic [FUNC_W-1:0] op;
    int                pick;
    int                g;
    int                k;
    int                m;
    int                s;
    opnd_t             an;
    opnd_t             ad;
    opnd_t             bn;
    opnd_t             bd;
    pick = $urandom_range(99);
    if (pick < 14) begin
      op = FUNC_ADD;
    end else if (pick < 28) begin
      op = FUNC_SUB;
    end else if (pick < 42) begin
      op = FUNC_MUL;
    end else if (pick < 56) begin
      op = FUNC_DIV;
    end else if (pick < 78) begin
      op = FUNC_RED;
    end else if (pick < 96) begin
      op = FUNC_CMP;
    end else begin
      op = ($urandom_range(1) != 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    end
    an = random_operand();
    ad = random_denominator();
    bn = random_operand();
    bd = random_denominator();
    // reduce with a shared factor so the gcd is not trivial
    if (op == FUNC_RED && $urandom_range(1) != 0) begin
      g  = $urandom_range(200, 1);
      k  = int'($urandom_range(300)) - 150;
      m  = int'($urandom_range(300)) - 150;
      an = opnd_t'(k * g);
      ad = opnd_t'(m * g);
    end
    // compare against an equal fraction scaled by a small factor
    if (op == FUNC_CMP && $urandom_range(2) == 0) begin
      s  = int'($urandom_range(10)) - 5;
      if (s == 0) s = 3;
      an = opnd_t'(int'($urandom_range(400)) - 200);
      ad = opnd_t'(int'($urandom_range(400)) - 200);
      bn = opnd_t'(int'(an) * s);
      bd = opnd_t'(int'(ad) * s);
    end
    send_request(op, an, ad, bn, bd);
  endtask

  // corners of every operation and the special cases
  task automatic test_directed();
    send_request(FUNC_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_request(FUNC_ADD, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(FUNC_ADD, 16'sd5, 16'sd0, 16'sd1, 16'sd3);
    send_request(FUNC_ADD, 16'sd0, 16'sd1, 16'sd0, 16'sd1);
    send_request(FUNC_SUB, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_request(FUNC_SUB, 16'sh8000, 16'sd1, 16'sh7fff, -16'sd1);
    send_request(FUNC_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(FUNC_MUL, 16'sd3, 16'sd4, 16'sd5, 16'sd0);
    send_request(FUNC_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5);
    send_request(FUNC_DIV, 16'sh8000, 16'sd7, 16'sh8000, -16'sd3);
    // reduce: zero over zero, zero numerator, most negative, sign, zero den
    send_request(FUNC_RED, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_request(FUNC_RED, 16'sd0, -16'sd7, 16'sd0, 16'sd1);
    send_request(FUNC_RED, 16'sh8000, 16'sh8000, 16'sd1, 16'sd1);
    send_request(FUNC_RED, 16'sd12, -16'sd18, 16'sd1, 16'sd1);
    send_request(FUNC_RED, 16'sd5, 16'sd0, 16'sd1, 16'sd1);
    send_request(FUNC_RED, 16'sh7fff, 16'sh8000, 16'sd1, 16'sd1);
    // compare: equal, negative denominators, zero denominator, extremes
    send_request(FUNC_CMP, 16'sd1, 16'sd2, 16'sd2, 16'sd4);
    send_request(FUNC_CMP, 16'sd1, -16'sd2, 16'sd1, 16'sd3);
    send_request(FUNC_CMP, -16'sd1, -16'sd2, 16'sd1, -16'sd3);
    send_request(FUNC_CMP, 16'sd3, 16'sd0, 16'sd1, 16'sd2);
    send_request(FUNC_CMP, 16'sh8000, 16'sd1, 16'sh7fff, 16'sd1);
    send_request(FUNC_CMP, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    // spare codes
    send_request(FUNC_SPARE_6, 16'sh7fff, 16'sd3, 16'sd1, 16'sd1);
    send_request(FUNC_SPARE_7, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    wait_drained();
  endtask

  // random requests with no idling on either side
  task automatic test_back_to_back(int count);
    no_idling = 1'b1;
    repeat (count) random_request();
    wait_drained();
    no_idling = 1'b0;
  endtask

  // random requests with idling on both sides and periodic drains
  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      random_request();
      if (i % 100 == 99) wait_drained();
    end
    wait_drained();
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= no_idling || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    fraction_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_num_o !== want.num) begin
          $error("res_num expected %0d got %0d", want.num, res_num_o);
          err_count++;
        end
        if (res_den_o !== want.den) begin
          $error("res_den expected %0d got %0d", want.den, res_den_o);
          err_count++;
        end
        if (cmp_result_o !== want.cmp) begin
          $error("cmp_result expected %0d got %0d", want.cmp, cmp_result_o);
          err_count++;
        end
        if (status_o !== want.status) begin
          $error("status expected %0b got %0b", want.status, status_o);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_back_to_back(150);
    test_random_traffic(880);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
